[rtl/brm_pkg.sv]
// shared widths, booth codes and controller interface types for the booth multiplier
package brm_pkg;

	localparam int WIDTH = 16;
	localparam int PROD_W = 2 * WIDTH;
	localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

	// {multiplier lsb, previous bit}
	localparam logic [1:0] BOOTH_ADD = 2'b01;
	localparam logic [1:0] BOOTH_SUB = 2'b10;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} brm_cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} brm_status_t;

endpackage

[rtl/booth_radix2_multiplier.sv]
// top level of the radix-2 booth signed multiplier
//
// input channel: in_valid / in_stall with multiplicand and multiplier, both signed
// 16-bit. an item is taken on a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with the signed 32-bit product, one
// result item for every input item, in order.
// each item is loaded in the cycle it is accepted, then goes through 16 booth
// steps, one add-or-subtract and arithmetic shift per cycle while the step is
// not held for a stalled output register. the product lands in the output
// register with the last step, which also raises out_valid. in_stall is low
// only while the sequencer is idle, so one item at a time goes through the
// datapath and a new item waits for the last step of the one before.
// the output register parts the two sides: a new item is accepted while the
// previous product still waits. if the receiver stalls with the register full,
// the last booth step of the next item holds until the product is taken.
// reset (arst_n low, asynchronous) empties the output register and returns the
// sequencer to idle; no item in flight survives it.
module booth_radix2_multiplier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [brm_pkg::WIDTH-1:0]  multiplicand,
	input  logic signed [brm_pkg::WIDTH-1:0]  multiplier,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [brm_pkg::PROD_W-1:0] product
);
	import brm_pkg::*;

	// commands from sequencer, status back from datapath
	brm_cmd_t    cmd;
	brm_status_t status;

	// one-hot sequencer: idle takes an item, busy runs the booth steps
	brm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// working register {acc, q, q1}, step counter and product register
	brm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.multiplicand (multiplicand),
		.multiplier   (multiplier),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.product      (product)
	);

endmodule

[rtl/brm_ctrl.sv]
// sequencer for load, booth steps and hand-off to the output register
module brm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  brm_pkg::brm_status_t status,
	output brm_pkg::brm_cmd_t    cmd
);
	import brm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b0 | 1'b1;
					state_d  = ST_BUSY;
				end
			end
			ST_BUSY: begin
				// last step waits until the output register can take the product
				cmd.step   = !status.last || status.out_free;
				cmd.finish = status.last && status.out_free;
				if (cmd.finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_finish_leaves_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE)
		else $error("finish did not return to idle");

	a_load_enters_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_BUSY)
		else $error("load did not start a run");

	a_finish_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> cmd.step)
		else $error("finish without a step");

endmodule

[rtl/brm_datapath.sv]
// accumulator, shifting multiplier, step counter and output register
module brm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  brm_pkg::brm_cmd_t           cmd,
	output brm_pkg::brm_status_t        status,
	input  logic signed [brm_pkg::WIDTH-1:0]  multiplicand,
	input  logic signed [brm_pkg::WIDTH-1:0]  multiplier,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [brm_pkg::PROD_W-1:0] product
);
	import brm_pkg::*;

	logic [WIDTH-1:0]  m_q;
	logic [WIDTH-1:0]  acc_q;
	logic [WIDTH-1:0]  q_q;
	logic              q1_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [PROD_W-1:0] product_q;

	logic [WIDTH-1:0]  acc_sum;
	logic [WIDTH-1:0]  acc_next;
	logic [WIDTH-1:0]  q_next;

	// add or subtract, then shift {acc, q, q1} right arithmetically
	always_comb begin
		unique case ({q_q[0], q1_q})
			BOOTH_ADD: acc_sum = acc_q + m_q;
			BOOTH_SUB: acc_sum = acc_q - m_q;
			default:   acc_sum = acc_q;
		endcase
		acc_next = {acc_sum[WIDTH-1], acc_sum[WIDTH-1:1]};
		q_next   = {acc_sum[0], q_q[WIDTH-1:1]};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= multiplicand;
			acc_q <= '0;
			q_q   <= multiplier;
			q1_q  <= 1'b0;
		end else if (cmd.step) begin
			acc_q <= acc_next;
			q_q   <= q_next;
			q1_q  <= q_q[0];
		end
		if (cmd.finish) begin
			product_q <= {acc_next, q_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.last     = (cnt_q == LAST_STEP);
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign product         = product_q;

	a_finish_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished product not presented");

	a_finish_on_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> cnt_q == LAST_STEP)
		else $error("finish before the last booth step");

	a_load_clears_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cnt_q == '0 && acc_q == '0 && !q1_q)
		else $error("load did not clear the working register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !cmd.finish)
		else $error("product overwritten while stalled");

endmodule
